// File: hw/rtl/cache_entry_table_lfu_eviction_assert.svh
// ----------------------------------------------------------------------------
// Cache entry table assertion macros
// Property macros for simulation; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef CACHE_ENTRY_TABLE_LFU_EVICTION_ASSERT_SVH
`define CACHE_ENTRY_TABLE_LFU_EVICTION_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define CETL_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cetl assertion failed");
// Next-cycle implication.
`define CETL_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cetl assertion failed");
`else
`define CETL_ASSERT_IMP(name, clk, rst, ante, cons)
`define CETL_ASSERT_NXT(name, clk, rst, ante, cons)
`endif

`endif

// File: hw/rtl/cetl_pkg.sv
// ----------------------------------------------------------------------------
// Cache entry table package
// Sizes, request and status codes, controller states and command types.
// ----------------------------------------------------------------------------
package cetl_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
   localparam int ID_BITS     = 16;
   localparam int TIME_BITS   = 32;
   localparam int USE_BITS    = 16;
   localparam int SCORE_BITS  = 31;
   localparam logic [SCORE_BITS-1:0] SCORE_MAX = {SCORE_BITS{1'b1}};
   localparam logic [USE_BITS-1:0]   USES_MAX  = {USE_BITS{1'b1}};

   // Request codes.
   localparam logic [2:0] REQ_INSERT = 3'd0;
   localparam logic [2:0] REQ_USE    = 3'd1;
   localparam logic [2:0] REQ_REMOVE = 3'd2;
   localparam logic [2:0] REQ_PRUNE  = 3'd3;
   localparam logic [2:0] REQ_EVICT  = 3'd4;

   // Status codes.
   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_PRESENT   = 3'd1;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
   localparam logic [2:0] STAT_FULL      = 3'd3;
   localparam logic [2:0] STAT_EMPTY     = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DISPATCH, ST_FIND, ST_AUTO, ST_PRUNE, ST_EV_LOOK, ST_EV_WAIT, ST_EV_END
   } state_type;

   // What the result word carries besides status.
   typedef enum logic [2:0] {
      RES_ZERO, RES_KEY, RES_SLOT, RES_BUMP, RES_NEW, RES_FULL, RES_BEST
   } res_sel_type;

   typedef struct packed {
      logic        load;
      logic        idx_clr;
      logic        idx_inc;
      logic        cand_init;
      logic        cand_inc;
      logic        append;
      logic        bump;
      logic        compact;
      logic        compact_best;
      logic        div_start;
      logic        ev_cmp;
      logic        finish;
      logic [2:0]  res_status;
      res_sel_type res_sel;
   } cmd_type;

   typedef struct packed {
      logic [2:0] req;
      logic       auto_id;
      logic       rm_victim;
      logic       at_end;
      logic       hit;
      logic       cand_hit;
      logic       cand_last;
      logic       full;
      logic       empty;
      logic       expired;
      logic       zero_uses;
      logic       div_done;
      logic       rsp_busy;
   } sts_type;

endpackage

// File: hw/rtl/cache_entry_table_lfu_eviction.sv
// ----------------------------------------------------------------------------
// Cache entry table with least-frequently-used eviction
// Sixteen-entry ordered table serving insert, use, remove, prune and evict.
// ----------------------------------------------------------------------------
//  Channel   Ports    Direction   Contents
//  request   req_*    in          one request word per handshake
//  response  rsp_*    out         one result word per request
//
//  A request is taken only when the controller is idle; the next request may
//  be taken while the previous result word still waits in its register.
//  Insert, use and remove scan one entry per cycle.
//  Auto id insert rescans per rejected candidate.
//  Evict runs the serial divider once per used entry.
//  Reset empties the table at once; no clearing pass is needed.
module cache_entry_table_lfu_eviction (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [2:0]                     req_type,
   input  logic [cetl_pkg::ID_BITS-1:0]   req_entry_id,
   input  logic                           req_auto_id,
   input  logic [cetl_pkg::TIME_BITS-1:0] req_expiry_time,
   input  logic [cetl_pkg::TIME_BITS-1:0] req_cached_at,
   input  logic                           req_keep_cached_at,
   input  logic [cetl_pkg::USE_BITS-1:0]  req_initial_uses,
   input  logic [cetl_pkg::TIME_BITS-1:0] req_now_time,
   input  logic                           req_remove_victim,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [2:0]                     rsp_status,
   output logic [cetl_pkg::ID_BITS-1:0]   rsp_result_id,
   output logic [cetl_pkg::CNT_BITS-1:0]  rsp_removed_count,
   output logic [cetl_pkg::CNT_BITS-1:0]  rsp_entry_count,
   output logic [cetl_pkg::USE_BITS-1:0]  rsp_use_count
);
   import cetl_pkg::*;

`include "cache_entry_table_lfu_eviction_assert.svh"

   cmd_type cmd;
   sts_type sts;

   cetl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cetl_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_type           (req_type),
      .req_entry_id       (req_entry_id),
      .req_auto_id        (req_auto_id),
      .req_expiry_time    (req_expiry_time),
      .req_cached_at      (req_cached_at),
      .req_keep_cached_at (req_keep_cached_at),
      .req_initial_uses   (req_initial_uses),
      .req_now_time       (req_now_time),
      .req_remove_victim  (req_remove_victim),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_result_id      (rsp_result_id),
      .rsp_removed_count  (rsp_removed_count),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_use_count      (rsp_use_count)
   );

   // A taken request leaves the controller busy in the next cycle.
   `CETL_ASSERT_NXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready)
   // Removals are only reported with a success status.
   `CETL_ASSERT_IMP(a_removed_ok, clock, reset, rsp_valid && rsp_removed_count != 0, rsp_status == STAT_OK)
   // An empty-table answer leaves no entries behind.
   `CETL_ASSERT_IMP(a_empty_count, clock, reset, rsp_valid && rsp_status == STAT_EMPTY, rsp_entry_count == 0)

endmodule

// File: hw/rtl/cetl_divider.sv
// ----------------------------------------------------------------------------
// Cache entry table divider
// Restoring radix-2 divider: one quotient bit per cycle, quotient held after.
// ----------------------------------------------------------------------------
module cetl_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [cetl_pkg::TIME_BITS-1:0] dividend,
   input  logic [cetl_pkg::USE_BITS-1:0]  divisor,
   output logic                           done,
   output logic [cetl_pkg::TIME_BITS-1:0] quotient
);
   import cetl_pkg::*;

   localparam int STEP_BITS = $clog2(TIME_BITS + 1);

   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [STEP_BITS-1:0] cnt_ff, cnt_in;
   logic [USE_BITS-1:0]  rem_ff, rem_in, div_ff, div_in;
   logic [TIME_BITS-1:0] quo_ff, quo_in;
   logic [USE_BITS:0]    trial, diff;

   // One shift and trial subtract per cycle.
   always_comb begin
      trial   = {rem_ff, quo_ff[TIME_BITS-1]};
      diff    = trial - {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = STEP_BITS'(TIME_BITS);
         rem_in  = '0;
         div_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (!diff[USE_BITS]) begin
            rem_in = diff[USE_BITS-1:0];
            quo_in = {quo_ff[TIME_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[USE_BITS-1:0];
            quo_in = {quo_ff[TIME_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: hw/rtl/cetl_datapath.sv
// ----------------------------------------------------------------------------
// Cache entry table datapath
// Entry table, scan index, id candidate, eviction scoring and result word.
// ----------------------------------------------------------------------------
module cetl_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  cetl_pkg::cmd_type              cmd,
   output cetl_pkg::sts_type              sts,
   input  logic [2:0]                     req_type,
   input  logic [cetl_pkg::ID_BITS-1:0]   req_entry_id,
   input  logic                           req_auto_id,
   input  logic [cetl_pkg::TIME_BITS-1:0] req_expiry_time,
   input  logic [cetl_pkg::TIME_BITS-1:0] req_cached_at,
   input  logic                           req_keep_cached_at,
   input  logic [cetl_pkg::USE_BITS-1:0]  req_initial_uses,
   input  logic [cetl_pkg::TIME_BITS-1:0] req_now_time,
   input  logic                           req_remove_victim,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [2:0]                     rsp_status,
   output logic [cetl_pkg::ID_BITS-1:0]   rsp_result_id,
   output logic [cetl_pkg::CNT_BITS-1:0]  rsp_removed_count,
   output logic [cetl_pkg::CNT_BITS-1:0]  rsp_entry_count,
   output logic [cetl_pkg::USE_BITS-1:0]  rsp_use_count
);
   import cetl_pkg::*;

   // Table storage.
   logic [ID_BITS-1:0]   slot_id_ff[TABLE_DEPTH],   slot_id_in[TABLE_DEPTH];
   logic [TIME_BITS-1:0] slot_time_ff[TABLE_DEPTH], slot_time_in[TABLE_DEPTH];
   logic [TIME_BITS-1:0] slot_exp_ff[TABLE_DEPTH],  slot_exp_in[TABLE_DEPTH];
   logic [USE_BITS-1:0]  slot_uses_ff[TABLE_DEPTH], slot_uses_in[TABLE_DEPTH];
   logic [CNT_BITS-1:0]  fill_ff, fill_in;

   // Latched request.
   logic [2:0]           req_ff;
   logic [ID_BITS-1:0]   key_ff;
   logic                 auto_ff, keep_ff, rmv_ff;
   logic [TIME_BITS-1:0] exp_ff, cached_ff, now_ff;
   logic [USE_BITS-1:0]  init_ff;

   // Scan and scoring state.
   logic [CNT_BITS-1:0]   idx_ff, idx_in, removed_ff, removed_in;
   logic [ID_BITS-1:0]    cand_ff, cand_in;
   logic [IDX_BITS-1:0]   best_idx_ff, best_idx_in;
   logic [SCORE_BITS-1:0] best_score_ff, best_score_in;
   logic [TIME_BITS-1:0]  best_time_ff, best_time_in;
   logic [ID_BITS-1:0]    best_id_ff, best_id_in;
   logic [USE_BITS-1:0]   best_uses_ff, best_uses_in;

   // Result word.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_status_ff;
   logic [ID_BITS-1:0]   rsp_id_ff, res_id;
   logic [CNT_BITS-1:0]  rsp_removed_ff, rsp_entry_ff;
   logic [USE_BITS-1:0]  rsp_uses_ff, res_uses;

   logic [IDX_BITS-1:0]   rd_idx, ci;
   logic [ID_BITS-1:0]    rd_id, new_id;
   logic [TIME_BITS-1:0]  rd_time, age, quotient;
   logic [USE_BITS-1:0]   rd_uses, bumped;
   logic [SCORE_BITS-1:0] score;
   logic                  div_done, take;

   assign rd_idx  = idx_ff[IDX_BITS-1:0];
   assign rd_id   = slot_id_ff[rd_idx];
   assign rd_time = slot_time_ff[rd_idx];
   assign rd_uses = slot_uses_ff[rd_idx];
   assign bumped  = (rd_uses == USES_MAX) ? rd_uses : rd_uses + 1'b1;
   assign new_id  = auto_ff ? cand_ff : key_ff;
   assign age     = (now_ff >= rd_time) ? now_ff - rd_time : '0;
   assign ci      = cmd.compact_best ? best_idx_ff : rd_idx;

   cetl_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (age),
      .divisor  (rd_uses),
      .done     (div_done),
      .quotient (quotient)
   );

   // Score of the entry under the scan index, saturated.
   always_comb begin
      if (rd_uses == '0) begin
         score = SCORE_MAX;
      end else if (quotient > TIME_BITS'(SCORE_MAX)) begin
         score = SCORE_MAX;
      end else begin
         score = quotient[SCORE_BITS-1:0];
      end
      take = (idx_ff == '0) || (score > best_score_ff) ||
             ((score == best_score_ff) && (rd_time < best_time_ff));
   end

   // Table updates: compaction, append and use count increment.
   always_comb begin
      slot_id_in   = slot_id_ff;
      slot_time_in = slot_time_ff;
      slot_exp_in  = slot_exp_ff;
      slot_uses_in = slot_uses_ff;
      fill_in      = fill_ff;
      if (cmd.compact) begin
         for (int j = 0; j < TABLE_DEPTH - 1; j++) begin
            if (IDX_BITS'(j) >= ci) begin
               slot_id_in[j]   = slot_id_ff[j+1];
               slot_time_in[j] = slot_time_ff[j+1];
               slot_exp_in[j]  = slot_exp_ff[j+1];
               slot_uses_in[j] = slot_uses_ff[j+1];
            end
         end
         fill_in = fill_ff - 1'b1;
      end
      if (cmd.append) begin
         slot_id_in[fill_ff[IDX_BITS-1:0]]   = new_id;
         slot_time_in[fill_ff[IDX_BITS-1:0]] = keep_ff ? cached_ff : now_ff;
         slot_exp_in[fill_ff[IDX_BITS-1:0]]  = exp_ff;
         slot_uses_in[fill_ff[IDX_BITS-1:0]] = init_ff;
         fill_in = fill_ff + 1'b1;
      end
      if (cmd.bump) begin
         slot_uses_in[rd_idx] = bumped;
      end
   end

   // Scan index, candidate id, removal count and best entry.
   always_comb begin
      idx_in        = idx_ff;
      cand_in       = cand_ff;
      removed_in    = removed_ff;
      best_idx_in   = best_idx_ff;
      best_score_in = best_score_ff;
      best_time_in  = best_time_ff;
      best_id_in    = best_id_ff;
      best_uses_in  = best_uses_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.cand_init) begin
         cand_in = ID_BITS'(1);
      end else if (cmd.cand_inc) begin
         cand_in = cand_ff + 1'b1;
      end
      if (cmd.load) begin
         removed_in = '0;
      end else if (cmd.compact) begin
         removed_in = removed_ff + 1'b1;
      end
      if (cmd.ev_cmp && take) begin
         best_idx_in   = rd_idx;
         best_score_in = score;
         best_time_in  = rd_time;
         best_id_in    = rd_id;
         best_uses_in  = rd_uses;
      end
   end

   // Result id, use count and result valid flag.
   always_comb begin
      case (cmd.res_sel)
         RES_KEY: begin
            res_id = key_ff;   res_uses = '0;
         end
         RES_SLOT: begin
            res_id = key_ff;   res_uses = rd_uses;
         end
         RES_BUMP: begin
            res_id = key_ff;   res_uses = bumped;
         end
         RES_NEW: begin
            res_id = new_id;   res_uses = init_ff;
         end
         RES_FULL: begin
            res_id = auto_ff ? '0 : key_ff;   res_uses = '0;
         end
         RES_BEST: begin
            res_id = best_id_ff;   res_uses = best_uses_ff;
         end
         default: begin
            res_id = '0;   res_uses = '0;
         end
      endcase
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      slot_id_ff    <= slot_id_in;
      slot_time_ff  <= slot_time_in;
      slot_exp_ff   <= slot_exp_in;
      slot_uses_ff  <= slot_uses_in;
      idx_ff        <= idx_in;
      cand_ff       <= cand_in;
      removed_ff    <= removed_in;
      best_idx_ff   <= best_idx_in;
      best_score_ff <= best_score_in;
      best_time_ff  <= best_time_in;
      best_id_ff    <= best_id_in;
      best_uses_ff  <= best_uses_in;
      if (cmd.load) begin
         req_ff    <= req_type;
         key_ff    <= req_entry_id;
         auto_ff   <= req_auto_id;
         exp_ff    <= req_expiry_time;
         cached_ff <= req_cached_at;
         keep_ff   <= req_keep_cached_at;
         init_ff   <= req_initial_uses;
         now_ff    <= req_now_time;
         rmv_ff    <= req_remove_victim;
      end
      if (cmd.finish) begin
         rsp_status_ff  <= cmd.res_status;
         rsp_id_ff      <= res_id;
         rsp_removed_ff <= removed_in;
         rsp_entry_ff   <= fill_in;
         rsp_uses_ff    <= res_uses;
      end
   end

   // Status toward the controller.
   always_comb begin
      sts.req       = req_ff;
      sts.auto_id   = auto_ff;
      sts.rm_victim = rmv_ff;
      sts.at_end    = (idx_ff == fill_ff);
      sts.hit       = (rd_id == key_ff);
      sts.cand_hit  = (rd_id == cand_ff);
      sts.cand_last = (cand_ff == {ID_BITS{1'b1}});
      sts.full      = (fill_ff == CNT_BITS'(TABLE_DEPTH));
      sts.empty     = (fill_ff == '0);
      sts.expired   = (slot_exp_ff[rd_idx] < now_ff);
      sts.zero_uses = (rd_uses == '0);
      sts.div_done  = div_done;
      sts.rsp_busy  = rsp_valid_ff;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_id     = rsp_id_ff;
   assign rsp_removed_count = rsp_removed_ff;
   assign rsp_entry_count   = rsp_entry_ff;
   assign rsp_use_count     = rsp_uses_ff;

endmodule

// File: hw/rtl/cetl_ctrl.sv
// ----------------------------------------------------------------------------
// Cache entry table controller
// Sequences the table scan for each request and issues datapath commands.
// ----------------------------------------------------------------------------
module cetl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cetl_pkg::sts_type sts,
   output cetl_pkg::cmd_type cmd
);
   import cetl_pkg::*;

   state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (!sts.rsp_busy) begin
               case (sts.req)
                  REQ_INSERT: state_in = sts.auto_id ? ST_AUTO : ST_FIND;
                  REQ_USE:    state_in = ST_FIND;
                  REQ_REMOVE: state_in = ST_FIND;
                  REQ_PRUNE:  state_in = ST_PRUNE;
                  REQ_EVICT:  state_in = sts.empty ? ST_IDLE : ST_EV_LOOK;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_FIND: begin
            if (sts.at_end || sts.hit) state_in = ST_IDLE;
         end
         ST_AUTO: begin
            if (sts.at_end || (sts.cand_hit && sts.cand_last)) state_in = ST_IDLE;
         end
         ST_PRUNE: begin
            if (sts.at_end) state_in = ST_IDLE;
         end
         ST_EV_LOOK: begin
            if (sts.at_end) begin
               state_in = ST_EV_END;
            end else if (!sts.zero_uses) begin
               state_in = ST_EV_WAIT;
            end
         end
         ST_EV_WAIT: begin
            if (sts.div_done) state_in = ST_EV_LOOK;
         end
         ST_EV_END: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Commands.
   always_comb begin
      cmd            = '0;
      cmd.res_status = STAT_OK;
      cmd.res_sel    = RES_ZERO;
      req_ready      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DISPATCH: begin
            if (!sts.rsp_busy) begin
               cmd.idx_clr   = 1'b1;
               cmd.cand_init = 1'b1;
               if (sts.req == REQ_EVICT) begin
                  if (sts.empty) begin
                     cmd.finish     = 1'b1;
                     cmd.res_status = STAT_EMPTY;
                  end
               end else if (sts.req != REQ_INSERT && sts.req != REQ_USE &&
                            sts.req != REQ_REMOVE && sts.req != REQ_PRUNE) begin
                  cmd.finish = 1'b1;
               end
            end
         end
         ST_FIND: begin
            if (sts.at_end) begin
               cmd.finish = 1'b1;
               if (sts.req == REQ_INSERT) begin
                  if (sts.full) begin
                     cmd.res_status = STAT_FULL;
                     cmd.res_sel    = RES_FULL;
                  end else begin
                     cmd.append  = 1'b1;
                     cmd.res_sel = RES_NEW;
                  end
               end else begin
                  cmd.res_status = STAT_NOT_FOUND;
                  cmd.res_sel    = RES_KEY;
               end
            end else if (sts.hit) begin
               cmd.finish = 1'b1;
               case (sts.req)
                  REQ_INSERT: begin
                     cmd.res_status = STAT_PRESENT;
                     cmd.res_sel    = RES_SLOT;
                  end
                  REQ_USE: begin
                     cmd.bump    = 1'b1;
                     cmd.res_sel = RES_BUMP;
                  end
                  default: begin
                     cmd.compact = 1'b1;
                     cmd.res_sel = RES_SLOT;
                  end
               endcase
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_AUTO: begin
            if (sts.at_end) begin
               cmd.finish = 1'b1;
               if (sts.full) begin
                  cmd.res_status = STAT_FULL;
                  cmd.res_sel    = RES_FULL;
               end else begin
                  cmd.append  = 1'b1;
                  cmd.res_sel = RES_NEW;
               end
            end else if (sts.cand_hit) begin
               if (sts.cand_last) begin
                  cmd.finish     = 1'b1;
                  cmd.res_status = STAT_FULL;
                  cmd.res_sel    = RES_FULL;
               end else begin
                  cmd.cand_inc = 1'b1;
                  cmd.idx_clr  = 1'b1;
               end
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_PRUNE: begin
            if (sts.at_end) begin
               cmd.finish = 1'b1;
            end else if (sts.expired) begin
               cmd.compact = 1'b1;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_EV_LOOK: begin
            if (!sts.at_end) begin
               if (sts.zero_uses) begin
                  cmd.ev_cmp  = 1'b1;
                  cmd.idx_inc = 1'b1;
               end else begin
                  cmd.div_start = 1'b1;
               end
            end
         end
         ST_EV_WAIT: begin
            if (sts.div_done) begin
               cmd.ev_cmp  = 1'b1;
               cmd.idx_inc = 1'b1;
            end
         end
         ST_EV_END: begin
            cmd.finish       = 1'b1;
            cmd.res_sel      = RES_BEST;
            cmd.compact      = sts.rm_victim;
            cmd.compact_best = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: verif/cache_entry_table_lfu_eviction_tb.sv
// ----------------------------------------------------------------------------
// Cache entry table testbench
// Drives directed and random requests into the entry table and checks every
// response word against a behavioral model of the table kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cache_entry_table_lfu_eviction_tb;
   import cetl_pkg::*;

   localparam int IDLE_LIMIT  = 20000;
   localparam int DRAIN_WAIT  = 600;
   localparam int RANDOM_REQS = 500;

   // Request word as driven onto the req_ ports.
   typedef struct packed {
      logic [2:0]           kind;
      logic [ID_BITS-1:0]   id;
      logic                 auto_id;
      logic [TIME_BITS-1:0] expiry;
      logic [TIME_BITS-1:0] cached;
      logic                 keep;
      logic [USE_BITS-1:0]  uses;
      logic [TIME_BITS-1:0] now;
      logic                 rm_victim;
   } req_word_type;

   // Response word as seen on the rsp_ ports.
   typedef struct packed {
      logic [2:0]          status;
      logic [ID_BITS-1:0]  id;
      logic [CNT_BITS-1:0] removed;
      logic [CNT_BITS-1:0] count;
      logic [USE_BITS-1:0] uses;
   } rsp_word_type;

   // Directed row: request plus optional typed-in response.
   typedef struct packed {
      req_word_type rq;
      logic         has_rsp;
      rsp_word_type rs;
   } dir_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [2:0]           req_type;
   logic [ID_BITS-1:0]   req_entry_id;
   logic                 req_auto_id;
   logic [TIME_BITS-1:0] req_expiry_time;
   logic [TIME_BITS-1:0] req_cached_at;
   logic                 req_keep_cached_at;
   logic [USE_BITS-1:0]  req_initial_uses;
   logic [TIME_BITS-1:0] req_now_time;
   logic                 req_remove_victim;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [2:0]           rsp_status;
   logic [ID_BITS-1:0]   rsp_result_id;
   logic [CNT_BITS-1:0]  rsp_removed_count;
   logic [CNT_BITS-1:0]  rsp_entry_count;
   logic [USE_BITS-1:0]  rsp_use_count;

   cache_entry_table_lfu_eviction i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_type, .req_entry_id,
      .req_auto_id, .req_expiry_time, .req_cached_at, .req_keep_cached_at,
      .req_initial_uses, .req_now_time, .req_remove_victim, .rsp_valid,
      .rsp_ready, .rsp_status, .rsp_result_id, .rsp_removed_count,
      .rsp_entry_count, .rsp_use_count
   );

   // Bench copy of the table.
   logic [ID_BITS-1:0]   tbl_id     [TABLE_DEPTH];
   logic [TIME_BITS-1:0] tbl_cached [TABLE_DEPTH];
   logic [TIME_BITS-1:0] tbl_expiry [TABLE_DEPTH];
   logic [USE_BITS-1:0]  tbl_uses   [TABLE_DEPTH];
   int                   tbl_fill;

   rsp_word_type pending_rsp[$];
   int  errors;
   int  send_idle_pct;
   int  recv_idle_pct;
   bit  recv_hold;
   int  quiet_cycles;

   // Clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int find_entry(logic [ID_BITS-1:0] id);
      for (int i = 0; i < tbl_fill; i++)
         if (tbl_id[i] == id) return i;
      return -1;
   endfunction

   function automatic void drop_entry(int idx);
      for (int i = idx; i + 1 < tbl_fill; i++) begin
         tbl_id[i]     = tbl_id[i+1];
         tbl_cached[i] = tbl_cached[i+1];
         tbl_expiry[i] = tbl_expiry[i+1];
         tbl_uses[i]   = tbl_uses[i+1];
      end
      tbl_fill--;
   endfunction

   // Time between uses, saturated; an unused entry scores highest.
   function automatic logic [63:0] use_gap(int idx, logic [TIME_BITS-1:0] now);
      logic [63:0] age;
      logic [63:0] q;
      if (tbl_uses[idx] == 0) return 64'(SCORE_MAX);
      age = (now >= tbl_cached[idx]) ? 64'(now - tbl_cached[idx]) : 64'd0;
      q = age / tbl_uses[idx];
      return (q > 64'(SCORE_MAX)) ? 64'(SCORE_MAX) : q;
   endfunction

   // Applies one request to the bench table and returns the response.
   function automatic rsp_word_type table_apply(req_word_type rq);
      rsp_word_type r;
      int          s;
      int          best;
      bit          ok;
      logic [ID_BITS-1:0] id;
      logic [63:0] bs;
      logic [63:0] sc;
      r = '0;
      id = rq.id;
      case (rq.kind)
         REQ_INSERT: begin
            ok = 1;
            if (rq.auto_id) begin
               ok = 0;
               for (int c = 1; c < (1 << ID_BITS); c++)
                  if (find_entry(ID_BITS'(c)) < 0) begin
                     id = ID_BITS'(c);
                     ok = 1;
                     break;
                  end
               if (!ok) r.status = STAT_FULL;
            end else begin
               s = find_entry(id);
               if (s >= 0) begin
                  ok = 0;
                  r.status = STAT_PRESENT;
                  r.id = id;
                  r.uses = tbl_uses[s];
               end
            end
            if (ok) begin
               if (tbl_fill >= TABLE_DEPTH) begin
                  r.status = STAT_FULL;
                  r.id = rq.auto_id ? '0 : id;
               end else begin
                  tbl_id[tbl_fill]     = id;
                  tbl_cached[tbl_fill] = rq.keep ? rq.cached : rq.now;
                  tbl_expiry[tbl_fill] = rq.expiry;
                  tbl_uses[tbl_fill]   = rq.uses;
                  tbl_fill++;
                  r.status = STAT_OK;
                  r.id = id;
                  r.uses = rq.uses;
               end
            end
         end
         REQ_USE, REQ_REMOVE: begin
            s = find_entry(id);
            r.id = id;
            if (s < 0) r.status = STAT_NOT_FOUND;
            else if (rq.kind == REQ_USE) begin
               if (tbl_uses[s] != USES_MAX) tbl_uses[s]++;
               r.uses = tbl_uses[s];
            end else begin
               r.uses = tbl_uses[s];
               drop_entry(s);
               r.removed = 1;
            end
         end
         REQ_PRUNE: begin
            s = 0;
            while (s < tbl_fill) begin
               if (tbl_expiry[s] < rq.now) begin
                  drop_entry(s);
                  r.removed++;
               end else s++;
            end
         end
         REQ_EVICT: begin
            if (tbl_fill == 0) r.status = STAT_EMPTY;
            else begin
               best = 0;
               bs = use_gap(0, rq.now);
               for (int i = 1; i < tbl_fill; i++) begin
                  sc = use_gap(i, rq.now);
                  if (sc > bs || (sc == bs && tbl_cached[i] < tbl_cached[best])) begin
                     best = i;
                     bs = sc;
                  end
               end
               r.id = tbl_id[best];
               r.uses = tbl_uses[best];
               if (rq.rm_victim) begin
                  drop_entry(best);
                  r.removed = 1;
               end
            end
         end
         default: ;
      endcase
      r.count = CNT_BITS'(tbl_fill);
      return r;
   endfunction

   // Random request; ids from a small pool so hits are common.
   function automatic req_word_type random_req();
      req_word_type rq;
      int k;
      rq.kind = 3'($urandom_range(0, 99) < 40 ? REQ_INSERT : $urandom_range(1, 4));
      if ($urandom_range(0, 49) == 0) rq.kind = 3'($urandom_range(5, 7));
      k = $urandom_range(0, 9);
      rq.id = (k < 8) ? ID_BITS'($urandom_range(0, 24)) : ID_BITS'($urandom);
      rq.auto_id   = ($urandom_range(0, 3) == 0);
      rq.expiry    = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(900, 1100);
      rq.cached    = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1200);
      rq.keep      = $urandom_range(0, 1);
      rq.uses      = ($urandom_range(0, 3) == 0) ? USE_BITS'($urandom) :
                     USE_BITS'($urandom_range(0, 5));
      if ($urandom_range(0, 19) == 0) rq.uses = USES_MAX;
      rq.now       = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 1300);
      rq.rm_victim = $urandom_range(0, 1);
      return rq;
   endfunction

   function automatic req_word_type mk(logic [2:0] kind, logic [ID_BITS-1:0] id,
                                       logic auto_id, logic [TIME_BITS-1:0] expiry,
                                       logic [TIME_BITS-1:0] cached, logic keep,
                                       logic [USE_BITS-1:0] uses,
                                       logic [TIME_BITS-1:0] now, logic rm);
      req_word_type rq;
      rq = '{kind, id, auto_id, expiry, cached, keep, uses, now, rm};
      return rq;
   endfunction

   // Sends one word once the sender's idle roll allows it. Valid drops only
   // while the sender idles, so each falling edge sees one drive of valid.
   task automatic send_word(req_word_type rq);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_type           <= rq.kind;
      req_entry_id       <= rq.id;
      req_auto_id        <= rq.auto_id;
      req_expiry_time    <= rq.expiry;
      req_cached_at      <= rq.cached;
      req_keep_cached_at <= rq.keep;
      req_initial_uses   <= rq.uses;
      req_now_time       <= rq.now;
      req_remove_victim  <= rq.rm_victim;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(table_apply(rq));
      @(negedge clock);
   endtask

   // Stops offering words and waits until every expected word has come.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   // Receiver ready with random idling and an optional long hold-off.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (recv_hold) begin
            rsp_ready <= 1'b0;
            repeat (3000) @(negedge clock);
            recv_hold = 0;
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Response checking and watchdog.
   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (reset) quiet_cycles <= 0;
      else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $error("response word with nothing expected");
               errors++;
            end else begin
               exp_w = pending_rsp.pop_front();
               if (rsp_status !== exp_w.status) begin
                  $error("status exp %0d got %0d", exp_w.status, rsp_status); errors++;
               end
               if (rsp_result_id !== exp_w.id) begin
                  $error("result_id exp %0d got %0d", exp_w.id, rsp_result_id); errors++;
               end
               if (rsp_removed_count !== exp_w.removed) begin
                  $error("removed_count exp %0d got %0d", exp_w.removed,
                         rsp_removed_count); errors++;
               end
               if (rsp_entry_count !== exp_w.count) begin
                  $error("entry_count exp %0d got %0d", exp_w.count, rsp_entry_count);
                  errors++;
               end
               if (rsp_use_count !== exp_w.uses) begin
                  $error("use_count exp %0d got %0d", exp_w.uses, rsp_use_count);
                  errors++;
               end
            end
         end
      end
   end

   // Stimulus.
   initial begin
      dir_row_type rows[$];
      rsp_word_type got;
      errors = 0;
      recv_hold = 0;
      send_idle_pct = 27;
      recv_idle_pct = 69;
      tbl_fill = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = '0; req_entry_id = '0; req_auto_id = 0; req_expiry_time = '0;
      req_cached_at = '0; req_keep_cached_at = 0; req_initial_uses = '0;
      req_now_time = '0; req_remove_victim = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table; has_rsp rows carry a typed-in response.
      rows.push_back('{mk(REQ_EVICT, 0, 0, 0, 0, 0, 0, 0, 1), 1,
                       '{STAT_EMPTY, 16'd0, 5'd0, 5'd0, 16'd0}});
      rows.push_back('{mk(REQ_PRUNE, 0, 0, 0, 0, 0, 0, '1, 0), 1,
                       '{STAT_OK, 16'd0, 5'd0, 5'd0, 16'd0}});
      rows.push_back('{mk(REQ_USE, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0), 1,
                       '{STAT_NOT_FOUND, 16'hFFFF, 5'd0, 5'd0, 16'd0}});
      rows.push_back('{mk(REQ_REMOVE, 16'd0, 0, 0, 0, 0, 0, 0, 0), 1,
                       '{STAT_NOT_FOUND, 16'd0, 5'd0, 5'd0, 16'd0}});
      rows.push_back('{mk(REQ_INSERT, 16'hFFFF, 0, '1, '1, 1, USES_MAX, 0, 0), 1,
                       '{STAT_OK, 16'hFFFF, 5'd0, 5'd1, USES_MAX}});
      rows.push_back('{mk(REQ_USE, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0), 1,
                       '{STAT_OK, 16'hFFFF, 5'd0, 5'd1, USES_MAX}});
      rows.push_back('{mk(REQ_INSERT, 16'hFFFF, 0, 0, 0, 0, 3, 0, 0), 1,
                       '{STAT_PRESENT, 16'hFFFF, 5'd0, 5'd1, USES_MAX}});
      rows.push_back('{mk(REQ_INSERT, 0, 1, 5, 0, 0, 0, 100, 0), 1,
                       '{STAT_OK, 16'd1, 5'd0, 5'd2, 16'd0}});
      rows.push_back('{mk(REQ_INSERT, 0, 0, 50, 200, 1, 1, 10, 0), 0, '0});
      rows.push_back('{mk(REQ_INSERT, 7, 0, '1, '1, 1, 2, 0, 0), 0, '0});
      rows.push_back('{mk(REQ_EVICT, 0, 0, 0, 0, 0, 0, 1000, 0), 0, '0});
      rows.push_back('{mk(REQ_EVICT, 0, 0, 0, 0, 0, 0, '1, 1), 0, '0});
      rows.push_back('{mk(REQ_USE, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
      rows.push_back('{mk(3'd5, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
      rows.push_back('{mk(3'd7, '1, 1, '1, '1, 1, '1, '1, 1), 0, '0});
      rows.push_back('{mk(REQ_PRUNE, 0, 0, 0, 0, 0, 0, 60, 0), 0, '0});
      // Fill the table with auto ids, then overflow it.
      for (int i = 0; i < 17; i++)
         rows.push_back('{mk(REQ_INSERT, 0, 1, 2000, 0, 0, 16'(i % 3), 16'(i), 0), 0, '0});
      rows.push_back('{mk(REQ_INSERT, 16'h1234, 0, 0, 0, 0, 0, 0, 0), 0, '0});
      rows.push_back('{mk(REQ_EVICT, 0, 0, 0, 0, 0, 0, 500, 1), 0, '0});
      rows.push_back('{mk(REQ_PRUNE, 0, 0, 0, 0, 0, 0, '1, 0), 0, '0});

      foreach (rows[i]) begin
         send_word(rows[i].rq);
         if (rows[i].has_rsp) begin
            got = pending_rsp[pending_rsp.size()-1];
            if (got !== rows[i].rs) begin
               $error("directed row %0d: table exp %h got %h", i, rows[i].rs, got);
               errors++;
            end
         end
      end

      // Random phases with changing idle mix; a hold-off fills the block.
      for (int n = 0; n < RANDOM_REQS; n++) begin
         if (n == RANDOM_REQS / 3) begin
            wait_drained();
            send_idle_pct = 69;
            recv_idle_pct = 27;
         end
         if (n == 2 * RANDOM_REQS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            recv_hold = 1;
         end
         send_word(random_req());
      end

      wait_drained();
      repeat (DRAIN_WAIT) @(negedge clock);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/cetl_pkg.sv
hw/rtl/cetl_divider.sv
hw/rtl/cetl_datapath.sv
hw/rtl/cetl_ctrl.sv
hw/rtl/cache_entry_table_lfu_eviction.sv
verif/cache_entry_table_lfu_eviction_tb.sv
